>>> rtl/core/tcp_pkg.sv
// Package: command codes, register indexes and channel word types of the collision probe.
package tcp_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE_TILE = 2'd0,
    CMD_READ_TILE  = 2'd1,
    CMD_WRITE_DEF  = 2'd2,
    CMD_PROBE      = 2'd3
  } command_t;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TILE_SIZE  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic        layer;
    logic        direction;
    logic        match_kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] strip_length;
    logic [15:0] search_value;
    logic [7:0]  tile_value;
    logic [7:0]  def_index;
    logic [15:0] def_value;
  } cmd_word_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  read_tile;
    logic [15:0] read_def;
    logic        out_of_bounds;
  } rsp_word_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_word_t;

endpackage

>>> rtl/core/tcp_stream_if.sv
// Interface: valid/ready channel carrying one word of a given type.
interface tcp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/tcp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module tcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/tilemap_collision_probe.sv
// Top level: tile map store with tile read/write, definition write and strip probe.
//
// Tile map collision probe. Commands arrive one word at a time on cmd and each
// gives exactly one word on rsp. Tile layers and the definition table are plain
// memories with no reset; reading a never-written entry returns whatever it holds.
// One command is in work at a time. A probe first runs three divisions
// on a shared bit-serial divider (cross coordinate, start and end pixel by the
// tile size), then takes each tested position through bounds multiply, layer
// read, optional definition read (when matching on value1) and compare; a
// position outside the map skips both reads.
// A finished word waits in the output register; a new command is taken once the
// previous one has moved into it.
module tilemap_collision_probe
  import tcp_pkg::*;
#(
  parameter int MAP_CELLS = 4096,
  parameter int TILE_DEFS = 256
) (
  input  logic clk,
  input  logic rst,
  tcp_stream_if.sink   cmd,
  tcp_stream_if.source rsp,
  tcp_stream_if.sink   cfg
);
  localparam int AW = $clog2(MAP_CELLS);
  localparam int DW = $clog2(TILE_DEFS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_POS, S_ADDR, S_IDX, S_TILE, S_DEF, S_CMP, S_DEFW, S_FIN
  } state_t;

  state_t      state;
  cmd_word_t   item;
  logic [12:0] map_width;
  logic [12:0] map_height;
  logic [8:0]  tile_size;
  logic [8:0]  ts;

  // divider
  logic [1:0]  div_sel;
  logic [4:0]  div_cnt;
  logic [8:0]  div_rem;
  logic [16:0] div_quo;
  logic [9:0]  div_shift;
  logic        div_ge;
  logic [8:0]  div_rem_next;
  logic [16:0] div_quo_next;
  logic [16:0] fixed_q;
  logic [16:0] start_q;
  logic [16:0] end_q;
  logic [16:0] end_pix;

  // strip walk
  logic [17:0] p;
  logic [16:0] along;
  logic        last;
  logic        pos_last;
  logic [16:0] pos_along;

  // address path
  logic [16:0] col;
  logic [16:0] row;
  logic        inb;
  logic [25:0] prod;
  logic [26:0] idx;
  logic        idx_ok;
  logic [AW-1:0] map_addr;
  logic        cmp_skip;

  // data path
  logic [7:0]  tile;
  logic [15:0] defval;
  logic [7:0]  tile_rd;
  logic        tile_has_def;
  logic [31:0] tile_wide;
  logic [31:0] dindex_wide;
  logic [DW-1:0] def_raddr;
  logic [15:0] got;

  // result
  logic        res_hit;
  logic        res_oob;
  rsp_word_t   out_word;
  logic        out_valid;

  // memories
  logic        main_we;
  logic        data_we;
  logic        def_we;
  logic [7:0]  main_q;
  logic [7:0]  data_q;
  logic [15:0] def_q;

  assign ts = (tile_size == 9'd0) ? 9'd1 : tile_size;
  assign end_pix = {1'b0, (item.direction ? item.pos_y : item.pos_x)}
                   + {1'b0, item.strip_length};

  // one restoring division step
  assign div_shift    = {div_rem, div_quo[16]};
  assign div_ge       = div_shift >= {1'b0, ts};
  assign div_rem_next = div_ge ? 9'(div_shift - {1'b0, ts}) : div_shift[8:0];
  assign div_quo_next = {div_quo[15:0], div_ge};

  // position along the strip
  assign pos_last  = p >= {1'b0, end_pix};
  assign pos_along = pos_last ? end_q : along;

  // map index and bounds
  assign idx      = {10'd0, col} + {1'b0, prod};
  assign idx_ok   = inb && (idx < 27'(MAP_CELLS));
  assign map_addr = idx[AW-1:0];

  // tile and definition lookup
  assign tile_rd      = item.layer ? data_q : main_q;
  assign tile_wide    = {24'd0, tile_rd};
  assign tile_has_def = tile_wide < 32'(TILE_DEFS);
  assign def_raddr    = tile_wide[DW-1:0];
  assign dindex_wide  = {24'd0, item.def_index};
  assign got          = item.match_kind ? defval : {8'd0, tile};

  // memory writes
  assign main_we = (state == S_IDX) && idx_ok && (item.command == CMD_WRITE_TILE) && !item.layer;
  assign data_we = (state == S_IDX) && idx_ok && (item.command == CMD_WRITE_TILE) && item.layer;
  assign def_we  = (state == S_DEFW) && (dindex_wide < 32'(TILE_DEFS));

  tcp_ram #(.WIDTH(8), .DEPTH(MAP_CELLS)) u_main (
    .clk(clk), .we(main_we), .waddr(map_addr), .wdata(item.tile_value),
    .raddr(map_addr), .rdata(main_q)
  );
  tcp_ram #(.WIDTH(8), .DEPTH(MAP_CELLS)) u_data (
    .clk(clk), .we(data_we), .waddr(map_addr), .wdata(item.tile_value),
    .raddr(map_addr), .rdata(data_q)
  );
  tcp_ram #(.WIDTH(16), .DEPTH(TILE_DEFS)) u_defs (
    .clk(clk), .we(def_we), .waddr(dindex_wide[DW-1:0]), .wdata(item.def_value),
    .raddr(def_raddr), .rdata(def_q)
  );

  // handshakes
  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= 13'd64;
      map_height <= 13'd64;
      tile_size  <= 9'd16;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_MAP_WIDTH:  map_width  <= cfg.data.data[12:0];
        REG_MAP_HEIGHT: map_height <= cfg.data.data[12:0];
        REG_TILE_SIZE:  tile_size  <= cfg.data.data[8:0];
        default: ;
      endcase
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load the output register or drop the word taken by the sink
      if (state == S_FIN && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            item    <= cmd.data;
            res_hit <= 1'b0;
            res_oob <= 1'b0;
            tile    <= 8'd0;
            defval  <= 16'd0;
            col     <= {1'b0, cmd.data.pos_x};
            row     <= {1'b0, cmd.data.pos_y};
            last    <= 1'b1;
            div_sel <= 2'd0;
            div_cnt <= 5'd0;
            div_rem <= 9'd0;
            div_quo <= {1'b0, cmd.data.direction ? cmd.data.pos_x : cmd.data.pos_y};
            case (cmd.data.command)
              CMD_WRITE_DEF: state <= S_DEFW;
              CMD_PROBE:     state <= S_DIV;
              default:       state <= S_ADDR;
            endcase
          end
        end
        S_DIV: begin
          if (div_cnt == 5'd16) begin
            div_cnt <= 5'd0;
            div_rem <= 9'd0;
            div_sel <= div_sel + 2'd1;
            case (div_sel)
              2'd0: begin
                fixed_q <= div_quo_next;
                div_quo <= {1'b0, item.direction ? item.pos_y : item.pos_x};
              end
              2'd1: begin
                start_q <= div_quo_next;
                div_quo <= end_pix;
              end
              default: begin
                end_q <= div_quo_next;
                p     <= {2'b0, item.direction ? item.pos_y : item.pos_x};
                along <= start_q;
                state <= S_POS;
              end
            endcase
          end else begin
            div_rem <= div_rem_next;
            div_quo <= div_quo_next;
            div_cnt <= div_cnt + 5'd1;
          end
        end
        S_POS: begin
          last  <= pos_last;
          col   <= item.direction ? fixed_q : pos_along;
          row   <= item.direction ? pos_along : fixed_q;
          state <= S_ADDR;
        end
        S_ADDR: begin
          inb   <= (col < {4'd0, map_width}) && (row < {4'd0, map_height});
          prod  <= row[12:0] * map_width;
          state <= S_IDX;
        end
        S_IDX: begin
          if (!idx_ok) begin
            res_oob <= 1'b1;
            state   <= (item.command == CMD_PROBE && !last) ? S_CMP : S_FIN;
          end else if (item.command == CMD_WRITE_TILE) begin
            state <= S_FIN;
          end else begin
            state <= S_TILE;
          end
        end
        S_TILE: begin
          tile   <= tile_rd;
          defval <= 16'd0;
          if ((item.command == CMD_READ_TILE || item.match_kind) && tile_has_def) begin
            state <= S_DEF;
          end else begin
            state <= S_CMP;
          end
        end
        S_DEF: begin
          defval <= def_q;
          state  <= S_CMP;
        end
        S_CMP: begin
          if (item.command == CMD_READ_TILE) begin
            state <= S_FIN;
          end else if (!cmp_skip && got == item.search_value) begin
            res_hit <= 1'b1;
            state   <= S_FIN;
          end else if (last) begin
            state <= S_FIN;
          end else begin
            p     <= p + {9'd0, ts};
            along <= along + 17'd1;
            state <= S_POS;
          end
        end
        S_DEFW: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_word.hit           <= res_hit;
            out_word.read_tile     <= (item.command == CMD_READ_TILE) ? tile : 8'd0;
            out_word.read_def      <= (item.command == CMD_READ_TILE) ? defval : 16'd0;
            out_word.out_of_bounds <= res_oob;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the compare stage is reached without a lookup only for an outside position
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_skip <= 1'b0;
    end else if (state == S_IDX) begin
      cmp_skip <= !idx_ok;
    end
  end

  // at most one memory write per cycle
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({main_we, data_we, def_we}))
    else $error("more than one memory written in a cycle");

  // a hit never comes with read data
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.hit) |-> (out_word.read_tile == 8'd0 && out_word.read_def == 16'd0))
    else $error("hit word carries read data");

  // divider step count stays within the dividend width
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt <= 5'd16))
    else $error("divider ran past its last step");

endmodule
